// ===== rtl/hspt_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the level scaling function for the sound peak tracker.
// No dependencies.
package hspt_pkg;

  localparam int RAW_W = 12;
  localparam int LVL_W = 8;
  localparam int LEN_W = 8;
  localparam int SLOT_W = 4;
  localparam int HSPT_HISTORY_DEPTH = 3;
  localparam int QUEUE_DEPTH = 2;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // Exact reciprocals for dividends below 2^20, with a 32-bit shift.
  localparam logic [20:0] LIGHT_RECIP = 21'd1048833;
  localparam logic [20:0] LIGHT_LIMIT = 21'd1048320;
  localparam logic [20:0] SOUND_RECIP = 21'd2050104;
  localparam logic [20:0] SOUND_LIMIT = 21'd536320;

  typedef enum logic {
    REG_WINDOW_LEN = 1'b0,
    REG_GROUP_LEN  = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [LVL_W-1:0] light;
    logic [LVL_W-1:0] sound;
  } levels_t;

  typedef struct packed {
    logic [LVL_W-1:0]  light_level;
    logic [LVL_W-1:0]  sound_level;
    logic              window_closed;
    logic [LVL_W-1:0]  window_peak;
    logic              group_closed;
    logic [LVL_W-1:0]  group_peak;
    logic              history_written;
    logic [SLOT_W-1:0] history_slot;
  } result_t;

  function automatic logic [LVL_W-1:0] scale_sat(input logic [RAW_W-1:0] raw,
                                                 input logic [20:0] recip,
                                                 input logic [20:0] limit);
    logic [20:0] prod;
    logic [40:0] quot;
    prod = {raw, 9'b0} - {9'b0, raw};
    quot = {21'b0, prod[19:0]} * {20'b0, recip};
    if (prod >= limit) begin
      return {LVL_W{1'b1}};
    end
    return quot[39:32];
  endfunction

endpackage

// ===== rtl/hspt_front.sv =====
`timescale 1ns / 1ps
// Front stage: accepts sensor pairs and registers the scaled light and sound levels.
// Depends on hspt_pkg.
module hspt_front import hspt_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [RAW_W-1:0] in_light_raw,
  input  logic [RAW_W-1:0] in_sound_raw,
  output logic             fr_valid,
  input  logic             fr_ready,
  output levels_t          fr_data
);

  logic    valid_r;
  levels_t data_r;
  levels_t data_nxt;

  assign in_ready = !valid_r || fr_ready;
  assign fr_valid = valid_r;
  assign fr_data  = data_r;

  always_comb begin
    data_nxt.light = scale_sat(in_light_raw, LIGHT_RECIP, LIGHT_LIMIT);
    data_nxt.sound = scale_sat(in_sound_raw, SOUND_RECIP, SOUND_LIMIT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= data_nxt;
    end
  end

endmodule

// ===== rtl/hspt_queue.sv =====
`timescale 1ns / 1ps
// Short queue of scaled levels between the front stage and the peak tracker.
// Depends on hspt_pkg.
module hspt_queue import hspt_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push_valid,
  output logic    push_ready,
  input  levels_t push_data,
  output logic    pop_valid,
  input  logic    pop_ready,
  output levels_t pop_data
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  levels_t            entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W-1:0]   count_r;
  logic               push;
  logic               pop;

  assign push_ready = count_r != CNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_data   = entry_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/hspt_back.sv =====
`timescale 1ns / 1ps
// Back stage: window and group running maxima, history ring index and the result register.
// Depends on hspt_pkg.
module hspt_back import hspt_pkg::*; #(
  parameter int HISTORY_DEPTH = HSPT_HISTORY_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  output logic             q_ready,
  input  levels_t          q_data,
  input  logic [LEN_W-1:0] window_len,
  input  logic [LEN_W-1:0] group_len,
  output logic             res_valid,
  input  logic             res_ready,
  output result_t          res
);

  localparam int HIDX_W = $clog2(HISTORY_DEPTH + 1);

  logic [LEN_W-1:0]  win_cnt_r, win_cnt_nxt;
  logic [LVL_W-1:0]  win_max_r, win_max_nxt;
  logic [LEN_W-1:0]  grp_cnt_r, grp_cnt_nxt;
  logic [LVL_W-1:0]  grp_max_r, grp_max_nxt;
  logic [HIDX_W-1:0] hidx_r, hidx_nxt;
  logic              valid_r;
  result_t           res_r, res_nxt;
  logic              pop;

  assign q_ready   = !valid_r || res_ready;
  assign pop       = q_valid && q_ready;
  assign res_valid = valid_r;
  assign res       = res_r;

  always_comb begin
    win_cnt_nxt = win_cnt_r;
    win_max_nxt = win_max_r;
    grp_cnt_nxt = grp_cnt_r;
    grp_max_nxt = grp_max_r;
    hidx_nxt    = hidx_r;
    res_nxt     = '0;
    res_nxt.light_level = q_data.light;
    res_nxt.sound_level = q_data.sound;
    if (win_cnt_r < window_len) begin
      if (q_data.sound > win_max_r) begin
        win_max_nxt = q_data.sound;
      end
      win_cnt_nxt = win_cnt_r + 1'b1;
    end else begin
      res_nxt.window_closed = 1'b1;
      res_nxt.window_peak   = win_max_r;
      win_cnt_nxt = '0;
      win_max_nxt = '0;
      if (grp_cnt_r < group_len) begin
        if (win_max_r > grp_max_r) begin
          grp_max_nxt = win_max_r;
        end
        grp_cnt_nxt = grp_cnt_r + 1'b1;
      end else begin
        res_nxt.group_closed = 1'b1;
        res_nxt.group_peak   = grp_max_r;
        grp_cnt_nxt = '0;
        grp_max_nxt = '0;
        if (hidx_r < HIDX_W'(HISTORY_DEPTH)) begin
          res_nxt.history_written = 1'b1;
          res_nxt.history_slot    = SLOT_W'(hidx_r);
          hidx_nxt = hidx_r + 1'b1;
        end else begin
          hidx_nxt = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_cnt_r <= '0;
      win_max_r <= '0;
      grp_cnt_r <= '0;
      grp_max_r <= '0;
      hidx_r    <= '0;
      valid_r   <= 1'b0;
    end else begin
      if (pop) begin
        win_cnt_r <= win_cnt_nxt;
        win_max_r <= win_max_nxt;
        grp_cnt_r <= grp_cnt_nxt;
        grp_max_r <= grp_max_nxt;
        hidx_r    <= hidx_nxt;
      end
      if (q_ready) begin
        valid_r <= q_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= res_nxt;
    end
  end

endmodule

// ===== rtl/hierarchical_sound_peak_tracker.sv =====
`timescale 1ns / 1ps
// Top level of the hierarchical sound peak tracker: configuration registers and stage wiring.
// Depends on hspt_pkg, hspt_front, hspt_queue and hspt_back.

// The block takes one light and sound conversion pair per clock cycle when the output side
// is not stalled and returns one result per item, in order. Each item is registered in the
// scaling stage, then in the two-entry queue and then in the tracker that updates the window
// and group maxima, which with the counters are updated as each item is taken. Write
// window_len and group_len only while no item is in flight.
module hierarchical_sound_peak_tracker import hspt_pkg::*; #(
  parameter int HISTORY_DEPTH = HSPT_HISTORY_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [RAW_W-1:0]   in_light_raw,
  input  logic [RAW_W-1:0]   in_sound_raw,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [LVL_W-1:0]   out_light_level,
  output logic [LVL_W-1:0]   out_sound_level,
  output logic               out_window_closed,
  output logic [LVL_W-1:0]   out_window_peak,
  output logic               out_group_closed,
  output logic [LVL_W-1:0]   out_group_peak,
  output logic               out_history_written,
  output logic [SLOT_W-1:0]  out_history_slot,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [LEN_W-1:0] window_len_r;
  logic [LEN_W-1:0] group_len_r;
  reg_idx_t         reg_idx;
  logic             cfg_wr;
  logic             fr_valid, fr_ready;
  levels_t          fr_data;
  logic             q_valid, q_ready;
  levels_t          q_data;
  result_t          res;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_len_r <= LEN_W'(100);
      group_len_r  <= LEN_W'(100);
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_WINDOW_LEN: window_len_r <= pwdata[LEN_W-1:0];
        REG_GROUP_LEN:  group_len_r  <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WINDOW_LEN: prdata = {{(PDATA_W-LEN_W){1'b0}}, window_len_r};
      REG_GROUP_LEN:  prdata = {{(PDATA_W-LEN_W){1'b0}}, group_len_r};
      default:        prdata = '0;
    endcase
  end

  hspt_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_light_raw (in_light_raw),
    .in_sound_raw (in_sound_raw),
    .fr_valid     (fr_valid),
    .fr_ready     (fr_ready),
    .fr_data      (fr_data)
  );

  hspt_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_data  (fr_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  hspt_back #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_data     (q_data),
    .window_len (window_len_r),
    .group_len  (group_len_r),
    .res_valid  (out_valid),
    .res_ready  (out_ready),
    .res        (res)
  );

  assign out_light_level     = res.light_level;
  assign out_sound_level     = res.sound_level;
  assign out_window_closed   = res.window_closed;
  assign out_window_peak     = res.window_peak;
  assign out_group_closed    = res.group_closed;
  assign out_group_peak      = res.group_peak;
  assign out_history_written = res.history_written;
  assign out_history_slot    = res.history_slot;

endmodule

// ===== rtl/hspt_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the sound peak tracker, bound to the top level.
// Depends on hspt_pkg and hierarchical_sound_peak_tracker.
module hspt_checker import hspt_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [LVL_W-1:0]  out_light_level,
  input logic [LVL_W-1:0]  out_sound_level,
  input logic              out_window_closed,
  input logic [LVL_W-1:0]  out_window_peak,
  input logic              out_group_closed,
  input logic [LVL_W-1:0]  out_group_peak,
  input logic              out_history_written,
  input logic [SLOT_W-1:0] out_history_slot
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sound_level) &&
      $stable(out_light_level) && $stable(out_window_peak) && $stable(out_group_peak))
    else $error("Stalled result changed.");

  a_window_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_window_closed |-> out_window_peak == '0 && !out_group_closed)
    else $error("Window fields set without a window close.");

  a_group_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_group_closed |-> out_group_peak == '0 && !out_history_written)
    else $error("Group fields set without a group close.");

  a_slot_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_history_written |-> out_history_slot == '0)
    else $error("History slot set without a history write.");

endmodule

bind hierarchical_sound_peak_tracker hspt_checker u_hspt_checker (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for hierarchical_sound_peak_tracker: directed and random sample
// streams under varied idling and back pressure, checked against an in-bench peak model.
// Depends on hspt_pkg and the RTL of the block.
module testbench;
  import hspt_pkg::*;

  localparam int unsigned LEVEL_GAIN = 511;
  localparam int unsigned LIGHT_FULL_SCALE = 4095;
  localparam int unsigned SOUND_FULL_SCALE = 2095;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [RAW_W-1:0]   in_light_raw = '0;
  logic [RAW_W-1:0]   in_sound_raw = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [LVL_W-1:0]   out_light_level;
  logic [LVL_W-1:0]   out_sound_level;
  logic               out_window_closed;
  logic [LVL_W-1:0]   out_window_peak;
  logic               out_group_closed;
  logic [LVL_W-1:0]   out_group_peak;
  logic               out_history_written;
  logic [SLOT_W-1:0]  out_history_slot;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  logic [LEN_W-1:0] cfg_window_len = 8'd100;
  logic [LEN_W-1:0] cfg_group_len = 8'd100;
  logic [LEN_W-1:0] win_count = '0;
  logic [LVL_W-1:0] win_max = '0;
  logic [LEN_W-1:0] grp_count = '0;
  logic [LVL_W-1:0] grp_max = '0;
  logic [4:0]       hist_index = '0;

  result_t     pending_results[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        recv_hold = 1'b0;
  int          fail_count = 0;

  hierarchical_sound_peak_tracker DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [LVL_W-1:0] scaled_level(input logic [RAW_W-1:0] raw,
                                                    input int unsigned full_scale);
    int unsigned v;
    v = (int'(raw) * LEVEL_GAIN) / full_scale;
    return (v > 255) ? 8'hFF : v[7:0];
  endfunction

  function automatic result_t track_peaks(input logic [RAW_W-1:0] light_raw,
                                          input logic [RAW_W-1:0] sound_raw);
    result_t r;
    r = '0;
    r.light_level = scaled_level(light_raw, LIGHT_FULL_SCALE);
    r.sound_level = scaled_level(sound_raw, SOUND_FULL_SCALE);
    if (win_count < cfg_window_len) begin
      if (r.sound_level > win_max) win_max = r.sound_level;
      win_count = win_count + 1'b1;
    end else begin
      r.window_closed = 1'b1;
      r.window_peak = win_max;
      win_count = '0;
      win_max = '0;
      if (grp_count < cfg_group_len) begin
        if (r.window_peak > grp_max) grp_max = r.window_peak;
        grp_count = grp_count + 1'b1;
      end else begin
        r.group_closed = 1'b1;
        r.group_peak = grp_max;
        grp_count = '0;
        grp_max = '0;
        if (hist_index < HSPT_HISTORY_DEPTH) begin
          r.history_written = 1'b1;
          r.history_slot = hist_index[SLOT_W-1:0];
          hist_index = hist_index + 1'b1;
        end else begin
          hist_index = '0;
        end
      end
    end
    return r;
  endfunction

  task automatic set_idling(input int phase);
    case (phase % 4)
      0: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      1: begin
        send_idle_pct = 85;
        recv_stall_pct = 0;
      end
      2: begin
        send_idle_pct = 0;
        recv_stall_pct = 85;
      end
      default: begin
        send_idle_pct = 10;
        recv_stall_pct = 10;
      end
    endcase
  endtask

  task automatic send_sample(input logic [RAW_W-1:0] light_raw,
                             input logic [RAW_W-1:0] sound_raw);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_light_raw <= light_raw;
    in_sound_raw <= sound_raw;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(track_peaks(light_raw, sound_raw));
  endtask

  // Most sound samples stay below the saturation point so that peaks vary.
  task automatic send_random_sample();
    logic [RAW_W-1:0] sound_raw;
    if ($urandom_range(99) < 60) sound_raw = RAW_W'($urandom_range(1100));
    else sound_raw = RAW_W'($urandom);
    send_sample(RAW_W'($urandom), sound_raw);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [LEN_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'(4 * int'(idx));
    pwdata <= PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_WINDOW_LEN) cfg_window_len = value;
    else cfg_group_len = value;
  endtask

  task automatic configure(input logic [LEN_W-1:0] window_len,
                           input logic [LEN_W-1:0] group_len);
    write_reg(REG_WINDOW_LEN, window_len);
    write_reg(REG_GROUP_LEN, group_len);
  endtask

  task automatic check_field(input string field, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      fail_count++;
      if (fail_count <= 10) $display("Mismatch on %s: expected %0d, got %0d", field, exp_v, act_v);
    end
  endtask

  task automatic test_reset_lengths();
    set_idling(0);
    send_sample(12'h000, 12'h000);
    send_sample(12'hFFF, 12'hFFF);
    send_sample(12'hAAA, 12'h555);
    wait_idle();
  endtask

  // With both lengths zero every item closes a window and a group, so the ring fills and then wraps.
  task automatic test_extremes();
    logic [RAW_W-1:0] sounds [12] = '{12'd100, 12'd900, 12'd1046, 12'd0, 12'd2095, 12'd300,
                                      12'd50, 12'd1045, 12'hFFF, 12'd10, 12'd700, 12'd20};
    configure(8'd0, 8'd0);
    send_sample(12'h000, 12'h000);
    send_sample(12'hFFF, 12'hFFF);
    send_sample(12'd2043, 12'd1045);
    send_sample(12'd2044, 12'd1046);
    send_sample(12'h555, 12'hAAA);
    wait_idle();
    configure(8'd2, 8'd1);
    set_idling(3);
    for (int i = 0; i < 12; i++) send_sample(RAW_W'(i * 341), sounds[i]);
    wait_idle();
  endtask

  task automatic test_lowered_lengths();
    configure(8'd6, 8'd3);
    for (int i = 0; i < 4; i++) send_sample(RAW_W'(i * 1000), RAW_W'(200 + i * 150));
    wait_idle();
    write_reg(REG_WINDOW_LEN, 8'd2);
    send_sample(12'd77, 12'd400);
    wait_idle();
    configure(8'd0, 8'd0);
    send_sample(12'd1234, 12'd800);
    wait_idle();
  endtask

  task automatic test_long_window();
    configure(8'd255, 8'd0);
    for (int i = 0; i < 260; i++) begin
      set_idling(i / 65);
      send_random_sample();
    end
    wait_idle();
  endtask

  task automatic test_long_group();
    configure(8'd0, 8'd255);
    for (int i = 0; i < 260; i++) begin
      set_idling(i / 65 + 1);
      send_random_sample();
    end
    wait_idle();
  endtask

  task automatic test_random_lengths();
    logic [LEN_W-1:0] window_len;
    logic [LEN_W-1:0] group_len;
    for (int b = 0; b < 10; b++) begin
      if ($urandom_range(3) == 0) window_len = LEN_W'($urandom_range(40, 8));
      else window_len = LEN_W'($urandom_range(7));
      if ($urandom_range(3) == 0) group_len = LEN_W'($urandom_range(20, 6));
      else group_len = LEN_W'($urandom_range(5));
      configure(window_len, group_len);
      set_idling(b);
      for (int i = 0; i < 45; i++) send_random_sample();
      wait_idle();
    end
  endtask

  // The receiver holds off long enough for the pipeline to fill and stall the input.
  task automatic test_backpressure();
    configure(8'd3, 8'd2);
    set_idling(0);
    fork
      begin
        recv_hold <= 1'b1;
        repeat (60) @(posedge clk);
        recv_hold <= 1'b0;
      end
      begin
        repeat (30) send_random_sample();
      end
    join
    wait_idle();
  endtask

  always @(posedge clk) begin
    if (recv_hold) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : check_results
    result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("Unexpected result with nothing pending");
      end else begin
        exp_r = pending_results.pop_front();
        check_field("light_level", exp_r.light_level, out_light_level);
        check_field("sound_level", exp_r.sound_level, out_sound_level);
        check_field("window_closed", exp_r.window_closed, out_window_closed);
        check_field("window_peak", exp_r.window_peak, out_window_peak);
        check_field("group_closed", exp_r.group_closed, out_group_closed);
        check_field("group_peak", exp_r.group_peak, out_group_peak);
        check_field("history_written", exp_r.history_written, out_history_written);
        check_field("history_slot", exp_r.history_slot, out_history_slot);
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_lengths();
    test_extremes();
    test_lowered_lengths();
    test_long_window();
    test_long_group();
    test_random_lengths();
    test_backpressure();
    wait_idle();
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== hierarchical_sound_peak_tracker.f =====
rtl/hspt_pkg.sv
rtl/hspt_front.sv
rtl/hspt_queue.sv
rtl/hspt_back.sv
rtl/hierarchical_sound_peak_tracker.sv
rtl/hspt_checker.sv
tb/testbench.sv
